// ===== hw/rtl/bdq_pkg.sv =====
// Shared types, codes and sizes for the bounded deque with delete by key.
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_DELETE     = 3'd4;
    localparam logic [2:0] REQ_READ_FWD   = 3'd5;
    localparam logic [2:0] REQ_READ_BWD   = 3'd6;
    localparam logic [2:0] REQ_NOP        = 3'd7;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_NOKEY = 2'd3;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic [6:0]               count;
        logic                     last;
    } rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK,
        CELL_DELETE,
        CELL_ROT_FWD,
        CELL_ROT_BWD
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] wrap;
    } cell_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } link_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of the deque chain: holds an entry and trades it with its neighbors.
module bdq_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bdq_pkg::cell_ctrl_t        ctrl,
    input  logic [bdq_pkg::DATA_W-1:0] key,
    input  bdq_pkg::link_t             left,
    input  bdq_pkg::link_t             right,
    input  logic                       hit_in,
    output bdq_pkg::link_t             cur,
    output logic                       hit_out,
    output logic                       tail
);
    import bdq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // first match from the front: everything at or behind it closes the gap
    assign hit_out = hit_in | (valid_reg & (data_reg == key));
    assign tail = valid_reg & ~right.valid;
    assign cur.valid = valid_reg;
    assign cur.data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next = data_reg;
        case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_PUSH_FRONT:
            begin
                valid_next = left.valid;
                data_next = left.data;
            end
            CELL_PUSH_BACK:
            begin
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    data_next = ctrl.key;
                end
            end
            CELL_POP_FRONT:
            begin
                valid_next = right.valid;
                data_next = right.data;
            end
            CELL_POP_BACK:
            begin
                if (tail)
                    valid_next = 1'b0;
            end
            CELL_DELETE:
            begin
                if (hit_out)
                begin
                    valid_next = right.valid;
                    data_next = right.data;
                end
            end
            CELL_ROT_FWD:
            begin
                // tail wraps around to take the head entry
                if (valid_reg)
                    data_next = right.valid ? right.data : ctrl.wrap;
            end
            CELL_ROT_BWD:
            begin
                if (valid_reg)
                    data_next = left.data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// Request sequencer: decodes requests, tracks occupancy and streams read-outs.
module bdq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  bdq_pkg::req_t              req,
    input  logic                       found,
    input  logic [bdq_pkg::DATA_W-1:0] head_data,
    input  logic [bdq_pkg::DATA_W-1:0] tail_data,
    output bdq_pkg::cell_ctrl_t        cell_ctrl,
    output logic                       busy,
    output logic                       done,
    output bdq_pkg::rsp_t              rsp
);
    import bdq_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic             dir_bwd_reg;
    logic             dir_bwd_next;
    logic             done_reg;
    logic             done_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             is_full;
    logic             is_empty;

    assign is_full = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign busy = (state_reg == ST_READ);
    assign done = done_reg;
    assign rsp = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dir_bwd_next = dir_bwd_reg;
        done_next = 1'b0;
        rsp_next = '0;
        rsp_next.status = STATUS_OK;
        rsp_next.last = 1'b1;
        cell_ctrl.op = CELL_HOLD;
        cell_ctrl.key = req.value;
        cell_ctrl.wrap = head_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (req.req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            if (is_full)
                                rsp_next.status = STATUS_FULL;
                            else
                            begin
                                cell_ctrl.op = (req.req_type == REQ_PUSH_FRONT) ?
                                               CELL_PUSH_FRONT : CELL_PUSH_BACK;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            if (is_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else
                            begin
                                cell_ctrl.op = (req.req_type == REQ_POP_FRONT) ?
                                               CELL_POP_FRONT : CELL_POP_BACK;
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (is_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else if (found)
                            begin
                                cell_ctrl.op = CELL_DELETE;
                                cnt_next = cnt_reg - 1'b1;
                            end
                            else
                                rsp_next.status = STATUS_NOKEY;
                        end
                        REQ_READ_FWD, REQ_READ_BWD:
                        begin
                            if (is_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else
                            begin
                                // hold the result until the stream starts
                                done_next = 1'b0;
                                state_next = ST_READ;
                                rem_next = cnt_reg;
                                dir_bwd_next = (req.req_type == REQ_READ_BWD);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // emit the end entry and rotate the chain one place
                done_next = 1'b1;
                cell_ctrl.op = dir_bwd_reg ? CELL_ROT_BWD : CELL_ROT_FWD;
                rsp_next.element = dir_bwd_reg ? tail_data : head_data;
                rsp_next.last = (rem_reg == CNT_W'(1));
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        rsp_next.count = 7'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            rem_reg <= '0;
            dir_bwd_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            dir_bwd_reg <= dir_bwd_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// ===== hw/rtl/bounded_deque_with_key_delete_top.sv =====
// Push/pop/delete requests are applied at the edge that accepts them, which also registers their result.
// An accepted read-out of n entries strobes one result per cycle; busy is high while the cell
// chain rotates one place per cycle.
// Throughput: one update per cycle while busy is low; a read-out holds off the next transfer
// until the last result of its stream has been registered.
// Reset clears occupancy and all cell valid bits; entry data is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module bounded_deque_with_key_delete_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bdq_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output bdq_pkg::rsp_t  rsp
);
    import bdq_pkg::*;

    cell_ctrl_t        cell_ctrl;
    link_t             lnk [DEPTH];
    logic [DEPTH:0]    hit;
    logic [DEPTH-1:0]  tail;
    link_t             front_in;
    logic [DATA_W-1:0] tail_data;

    assign hit[0] = 1'b0;
    assign front_in.valid = 1'b1;
    assign front_in.data = (cell_ctrl.op == CELL_ROT_BWD) ? tail_data : cell_ctrl.key;

    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
            tail_data = tail_data | (tail[i] ? lnk[i].data : '0);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        link_t left_lnk;
        link_t right_lnk;

        if (i == 0)
        begin : g_first
            assign left_lnk = front_in;
        end
        else
        begin : g_mid
            assign left_lnk = lnk[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_lnk = '0;
        end
        else
        begin : g_inner
            assign right_lnk = lnk[i+1];
        end

        bdq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .key     (req.value),
            .left    (left_lnk),
            .right   (right_lnk),
            .hit_in  (hit[i]),
            .cur     (lnk[i]),
            .hit_out (hit[i+1]),
            .tail    (tail[i])
        );
    end

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .found     (hit[DEPTH]),
        .head_data (lnk[0].data),
        .tail_data (tail_data),
        .cell_ctrl (cell_ctrl),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

// ===== hw/rtl/bdq_checker.sv =====
// Port-level checks for the deque top level, attached by bind.
module bdq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input bdq_pkg::req_t req,
    input logic          busy,
    input logic          done,
    input bdq_pkg::rsp_t rsp
);
    import bdq_pkg::*;

    // more results pending: block must stay busy
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.last |-> busy)
        else $error("result stream open while not busy");

    // a read-out streams without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.last |=> done)
        else $error("gap in read-out stream");

    // non-read requests answer next cycle with a single result
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type != REQ_READ_FWD && req.req_type != REQ_READ_BWD
        |=> done && rsp.last)
        else $error("update result missing or not final");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.count <= 7'(DEPTH))
        else $error("count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != STATUS_OK |-> rsp.last && rsp.element == '0)
        else $error("error result carries data or is not final");

endmodule

bind bounded_deque_with_key_delete_top bdq_checker u_bdq_checker (.*);

// ===== sim/tb.sv =====
// Testbench for the bounded deque with delete by key: directed table, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 228;

    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    bounded_deque_with_key_delete_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the deque, entry 0 is the front
    logic signed [DATA_W-1:0] dq_mem [DEPTH];
    int                       dq_len = 0;
    rsp_t                     dq_out [$];

    rsp_t     pending_rsp [$];
    dir_row_t dir_rows [$];
    int       errors = 0;
    int       cycles = 0;
    bit       idle_on = 1'b1;

    function automatic req_t mk_req(logic [2:0] kind, logic signed [DATA_W-1:0] v);
        req_t r;
        r.req_type = kind;
        r.value = v;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic [1:0] st, logic signed [DATA_W-1:0] el, bit fin);
        rsp_t r;
        r.status = st;
        r.element = el;
        r.count = 7'(dq_len);
        r.last = fin;
        return r;
    endfunction

    function automatic rsp_t single_rsp(logic [1:0] st, int cnt);
        rsp_t r;
        r.status = st;
        r.element = '0;
        r.count = 7'(cnt);
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] kind, logic signed [DATA_W-1:0] v,
                                    bit fixed, rsp_t want);
        dir_row_t row;
        row.r = mk_req(kind, v);
        row.fixed = fixed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void remove_entry(int pos);
        for (int i = pos; i + 1 < dq_len; i++)
            dq_mem[i] = dq_mem[i + 1];
        dq_len--;
    endfunction

    // Update the shadow deque and collect the results one request causes
    task automatic deque_step(input req_t r);
        logic [1:0] st;
        int         hit;
        int         pos;
        st = STATUS_OK;
        hit = -1;
        dq_out.delete();
        case (r.req_type)
            REQ_PUSH_FRONT:
                if (dq_len >= DEPTH)
                    st = STATUS_FULL;
                else
                begin
                    for (int i = dq_len; i > 0; i--)
                        dq_mem[i] = dq_mem[i - 1];
                    dq_mem[0] = r.value;
                    dq_len++;
                end
            REQ_PUSH_BACK:
                if (dq_len >= DEPTH)
                    st = STATUS_FULL;
                else
                begin
                    dq_mem[dq_len] = r.value;
                    dq_len++;
                end
            REQ_POP_FRONT:
                if (dq_len == 0)
                    st = STATUS_EMPTY;
                else
                    remove_entry(0);
            REQ_POP_BACK:
                if (dq_len == 0)
                    st = STATUS_EMPTY;
                else
                    dq_len--;
            REQ_DELETE:
                if (dq_len == 0)
                    st = STATUS_EMPTY;
                else
                begin
                    for (int i = 0; i < dq_len; i++)
                        if (hit < 0 && dq_mem[i] == r.value)
                            hit = i;
                    if (hit < 0)
                        st = STATUS_NOKEY;
                    else
                        remove_entry(hit);
                end
            REQ_READ_FWD, REQ_READ_BWD:
            begin
                if (dq_len == 0)
                    dq_out.push_back(mk_rsp(STATUS_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < dq_len; i++)
                    begin
                        pos = (r.req_type == REQ_READ_FWD) ? i : dq_len - 1 - i;
                        dq_out.push_back(mk_rsp(STATUS_OK, dq_mem[pos], i == dq_len - 1));
                    end
                return;
            end
            default: ;
        endcase
        dq_out.push_back(mk_rsp(st, '0, 1'b1));
    endtask

    // Mode 0 fills, mode 1 drains, mode 2 mixes
    function automatic req_t random_req(int mode);
        int                       roll;
        int                       push_pct;
        int                       pop_pct;
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] v;
        push_pct = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
        pop_pct = (mode == 0) ? 10 : (mode == 1) ? 35 : 23;
        roll = $urandom_range(99);
        if (roll < push_pct)
            kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        else if (roll < 85)
            kind = REQ_DELETE;
        else if (roll < 98)
            kind = $urandom_range(1) ? REQ_READ_BWD : REQ_READ_FWD;
        else
            kind = REQ_NOP;
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2, 3: v = $urandom_range(7);
            default: v = $urandom();
        endcase
        // Mostly delete keys that are present
        if (kind == REQ_DELETE && dq_len > 0 && $urandom_range(99) < 70)
            v = dq_mem[$urandom_range(dq_len - 1)];
        return mk_req(kind, v);
    endfunction

    task automatic send_req(input req_t r, input bit fixed, input rsp_t want, input bit hold_off);
        while ((hold_off && pending_rsp.size() != 0) || (idle_on && $urandom_range(99) < 16))
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        // transfer taken at this edge
        deque_step(r);
        if (fixed)
            pending_rsp.push_back(want);
        else
            foreach (dq_out[i])
                pending_rsp.push_back(dq_out[i]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch($sformatf("result with nothing pending: %p", rsp));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
                if (rsp.element !== want.element)
                    report_mismatch($sformatf("element %0d, want %0d", rsp.element,
                                              want.element));
                if (rsp.count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d", rsp.count, want.count));
                if (rsp.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", rsp.last, want.last));
            end
        end
    end

    initial
    begin
        rsp_t none;
        int   mode;
        none = '0;
        foreach (dq_mem[i])
            dq_mem[i] = '0;

        // Requests on an empty deque
        add_row(REQ_READ_FWD, 32'sd5, 1'b1, single_rsp(STATUS_EMPTY, 0));
        add_row(REQ_READ_BWD, -32'sd5, 1'b1, single_rsp(STATUS_EMPTY, 0));
        add_row(REQ_POP_FRONT, '0, 1'b1, single_rsp(STATUS_EMPTY, 0));
        add_row(REQ_POP_BACK, '1, 1'b1, single_rsp(STATUS_EMPTY, 0));
        add_row(REQ_DELETE, '0, 1'b1, single_rsp(STATUS_EMPTY, 0));
        add_row(REQ_NOP, 32'sh7fff_ffff, 1'b1, single_rsp(STATUS_OK, 0));
        // Extremes, absent key, then removal of the tail and of the sole entry
        add_row(REQ_PUSH_BACK, 32'sh7fff_ffff, 1'b1, single_rsp(STATUS_OK, 1));
        add_row(REQ_PUSH_FRONT, 32'sh8000_0000, 1'b1, single_rsp(STATUS_OK, 2));
        add_row(REQ_DELETE, '0, 1'b1, single_rsp(STATUS_NOKEY, 2));
        add_row(REQ_DELETE, 32'sh7fff_ffff, 1'b1, single_rsp(STATUS_OK, 1));
        add_row(REQ_DELETE, 32'sh8000_0000, 1'b1, single_rsp(STATUS_OK, 0));
        // Fill to the brim
        for (int i = 0; i < DEPTH; i++)
            add_row(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom(), 1'b0, none);
        add_row(REQ_PUSH_FRONT, '1, 1'b1, single_rsp(STATUS_FULL, DEPTH));
        add_row(REQ_PUSH_BACK, '0, 1'b1, single_rsp(STATUS_FULL, DEPTH));
        add_row(REQ_READ_FWD, '0, 1'b0, none);
        add_row(REQ_READ_BWD, '0, 1'b0, none);
        add_row(REQ_NOP, '1, 1'b1, single_rsp(STATUS_OK, DEPTH));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].want, 1'b0);

        mode = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 24 == 0)
                mode = (mode + 1) % 3;
            idle_on = !(n >= 100 && n < 160);
            send_req(random_req(mode), 1'b0, none, n == 0 || n == 200);
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_deque_with_key_delete_top.sv
hw/rtl/bdq_checker.sv
sim/tb.sv
